// ----- hw/rtl/bpfs_pkg.sv -----
// Shared types and constants for the buddy page allocator core.
package bpfs_pkg;

   localparam int PAGE_TOTAL  = 4096;
   localparam int ORDER_COUNT = 11;
   localparam int PFN_W       = 12;
   localparam int ORD_W       = 4;
   localparam int LIMIT_W     = 13;
   localparam int CNT_W       = 13;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(PAGE_TOTAL);
   localparam logic [CNT_W-1:0]   COUNT_MAX   = '1;
   localparam logic [ORD_W-1:0]   ORDER_TOP   = ORD_W'(ORDER_COUNT - 1);
   localparam logic [ORD_W-1:0]   ORDER_LIM   = ORD_W'(ORDER_COUNT);
   localparam logic [ORD_W-1:0]   ORDER_TAIL  = ORD_W'(ORDER_COUNT - 2);
   localparam logic [PFN_W-1:0]   PFN_LAST    = PFN_W'(PAGE_TOTAL - 1);

   typedef enum logic {
      CMD_FREE  = 1'b0,
      CMD_SPLIT = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_ALIGN = 2'd1,
      ERR_RANGE = 2'd2
   } error_type;

   localparam logic REG_LIMIT = 1'b0;

   typedef struct packed {
      logic             free_head;
      logic [ORD_W-1:0] blk_order;
   } page_entry_type;

   typedef struct packed {
      logic             we;
      logic [PFN_W-1:0] waddr;
      page_entry_type   wdata;
      logic             re;
      logic [PFN_W-1:0] raddr;
   } mem_req_type;

endpackage

// ----- hw/rtl/bpfs_page_mem.sv -----
// Page entry memory: one write port, one read port with registered read data.
module bpfs_page_mem (
   input  logic                     clock,
   input  bpfs_pkg::mem_req_type    mem_req,
   output bpfs_pkg::page_entry_type rd_data
);
   import bpfs_pkg::*;

   page_entry_type page_mem [PAGE_TOTAL];
   page_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         page_mem[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= page_mem[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/buddy_page_free_and_split.sv -----
// Top level of the buddy page allocator core: command sequencer, counters and APB register.
//
// After reset the block sweeps the 4096-entry page memory, one entry per cycle, holding busy
// high during the sweep; register writes are taken during the sweep. A command is taken when
// start is high and busy is low; its result appears on the rsp_ ports for one cycle with
// rsp_valid, and the receiver cannot stall it. A rejected command returns its result in the
// cycle after acceptance. Each merge step of a free reads the buddy entry, then compares and
// writes it back; a final step marks the merged block, and one more step reads the higher
// buddy for the tail hint when that read applies. A split writes one upper half per cycle down
// to the target order. The single page memory port pair sets this sequencing.
module buddy_page_free_and_split (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [bpfs_pkg::PFN_W-1:0]    req_block_pfn,
   input  logic [bpfs_pkg::ORD_W-1:0]    req_order,
   input  logic [bpfs_pkg::ORD_W-1:0]    req_target_order,
   output logic                          rsp_valid,
   output logic [bpfs_pkg::PFN_W-1:0]    rsp_result_pfn,
   output logic [bpfs_pkg::ORD_W-1:0]    rsp_result_order,
   output logic                          rsp_tail_hint,
   output logic [1:0]                    rsp_error,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bpfs_pkg::ADDR_W-1:0]   paddr,
   input  logic [bpfs_pkg::DATA_W-1:0]   pwdata,
   output logic [bpfs_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import bpfs_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR     = 7'b000_0001,
      ST_IDLE      = 7'b000_0010,
      ST_FREE_RD   = 7'b000_0100,
      ST_FREE_EVAL = 7'b000_1000,
      ST_FINAL     = 7'b001_0000,
      ST_TAIL      = 7'b010_0000,
      ST_SPLIT     = 7'b100_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [PFN_W-1:0]     clr_ff, clr_in;
   logic [PFN_W-1:0]     pfn_ff, pfn_in;
   logic [ORD_W-1:0]     ord_ff, ord_in;
   logic [ORD_W-1:0]     tgt_ff, tgt_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PFN_W-1:0]     rsp_pfn_ff, rsp_pfn_in;
   logic [ORD_W-1:0]     rsp_ord_ff, rsp_ord_in;
   logic                 rsp_tail_ff, rsp_tail_in;
   error_type            rsp_err_ff, rsp_err_in;
   logic [CNT_W-1:0]     cnt_ff [ORDER_COUNT];

   mem_req_type          mem_req;
   page_entry_type       rd_data;

   logic                 cnt_up, cnt_dn;
   logic [ORD_W-1:0]     cnt_ord;

   logic [PFN_W-1:0]     buddy, base, hbuddy, half, align_mask;
   logic                 buddy_ok, hb_ok, cfg_wr;
   logic [ORD_W-1:0]     ord_up, ord_dn;

   bpfs_page_mem u_page_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign ord_up     = ord_ff + ORD_W'(1);
   assign ord_dn     = ord_ff - ORD_W'(1);
   assign buddy      = pfn_ff ^ (PFN_W'(1) << ord_ff);
   assign base       = pfn_ff & buddy;
   assign hbuddy     = base ^ (PFN_W'(1) << ord_up);
   assign half       = pfn_ff | (PFN_W'(1) << ord_dn);
   assign buddy_ok   = {1'b0, buddy} < limit_ff;
   assign hb_ok      = {1'b0, hbuddy} < limit_ff;
   assign align_mask = (PFN_W'(1) << req_order) - PFN_W'(1);

   assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_LIMIT);
   assign limit_in = cfg_wr ? pwdata[LIMIT_W-1:0] : limit_ff;
   assign prdata = (paddr[ADDR_W-1] == REG_LIMIT) ? DATA_W'(limit_ff) : '0;
   assign pready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pfn_in       = pfn_ff;
      ord_in       = ord_ff;
      tgt_in       = tgt_ff;
      rsp_valid_in = 1'b0;
      rsp_pfn_in   = rsp_pfn_ff;
      rsp_ord_in   = rsp_ord_ff;
      rsp_tail_in  = rsp_tail_ff;
      rsp_err_in   = rsp_err_ff;
      mem_req      = '0;
      cnt_up       = 1'b0;
      cnt_dn       = 1'b0;
      cnt_ord      = ord_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_ff;
            clr_in        = clr_ff + PFN_W'(1);
            if (clr_ff == PFN_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               pfn_in      = req_block_pfn;
               ord_in      = req_order;
               tgt_in      = req_target_order;
               rsp_pfn_in  = req_block_pfn;
               rsp_ord_in  = req_order;
               rsp_tail_in = 1'b0;
               rsp_err_in  = ERR_NONE;
               if (req_order >= ORDER_LIM ||
                   (req_command == CMD_SPLIT && req_target_order >= ORDER_LIM)) begin
                  rsp_err_in   = ERR_RANGE;
                  rsp_valid_in = 1'b1;
               end else if ((req_block_pfn & align_mask) != '0) begin
                  rsp_err_in   = ERR_ALIGN;
                  rsp_valid_in = 1'b1;
               end else if (req_command == CMD_FREE) begin
                  state_in = ST_FREE_RD;
               end else if (req_order > req_target_order) begin
                  state_in = ST_SPLIT;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_FREE_RD: begin
            if (ord_ff < ORDER_TOP && buddy_ok) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = buddy;
               state_in      = ST_FREE_EVAL;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_FREE_EVAL: begin
            if (rd_data.free_head && rd_data.blk_order == ord_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = buddy;
               cnt_dn        = 1'b1;
               pfn_in        = base;
               ord_in        = ord_up;
               state_in      = ST_FREE_RD;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            mem_req.we              = 1'b1;
            mem_req.waddr           = pfn_ff;
            mem_req.wdata.free_head = 1'b1;
            mem_req.wdata.blk_order = ord_ff;
            cnt_up                  = 1'b1;
            rsp_pfn_in              = pfn_ff;
            rsp_ord_in              = ord_ff;
            rsp_tail_in             = 1'b0;
            rsp_err_in              = ERR_NONE;
            if (ord_ff < ORDER_TAIL && buddy_ok && hb_ok) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = hbuddy;
               state_in      = ST_TAIL;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_TAIL: begin
            rsp_tail_in  = rd_data.free_head && rd_data.blk_order == ord_up;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SPLIT: begin
            mem_req.we              = 1'b1;
            mem_req.waddr           = half;
            mem_req.wdata.free_head = 1'b1;
            mem_req.wdata.blk_order = ord_dn;
            cnt_up                  = 1'b1;
            cnt_ord                 = ord_dn;
            ord_in                  = ord_dn;
            if (ord_dn == tgt_ff) begin
               rsp_pfn_in   = pfn_ff;
               rsp_ord_in   = tgt_ff;
               rsp_tail_in  = 1'b0;
               rsp_err_in   = ERR_NONE;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ORDER_COUNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_up && cnt_ff[cnt_ord] != COUNT_MAX) begin
            cnt_ff[cnt_ord] <= cnt_ff[cnt_ord] + CNT_W'(1);
         end else if (cnt_dn && cnt_ff[cnt_ord] != '0) begin
            cnt_ff[cnt_ord] <= cnt_ff[cnt_ord] - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      pfn_ff      <= pfn_in;
      ord_ff      <= ord_in;
      tgt_ff      <= tgt_in;
      rsp_pfn_ff  <= rsp_pfn_in;
      rsp_ord_ff  <= rsp_ord_in;
      rsp_tail_ff <= rsp_tail_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_pfn   = rsp_pfn_ff;
   assign rsp_result_order = rsp_ord_ff;
   assign rsp_tail_hint    = rsp_tail_ff;
   assign rsp_error        = rsp_err_ff;

endmodule

// ----- hw/rtl/bpfs_checker.sv -----
// Port-level checks for the buddy page allocator core, bound to the top level.
module bpfs_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic [bpfs_pkg::ORD_W-1:0] req_order,
   input logic                       rsp_valid,
   input logic [bpfs_pkg::ORD_W-1:0] rsp_result_order,
   input logic                       rsp_tail_hint,
   input logic [1:0]                 rsp_error
);
   import bpfs_pkg::*;

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error == ERR_NONE || rsp_error == ERR_ALIGN ||
                     rsp_error == ERR_RANGE))
      else $error("undefined error code on result");

   a_tail_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != ERR_NONE |-> !rsp_tail_hint)
      else $error("tail hint set on a rejected transaction");

   a_range_reject: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_order >= ORDER_LIM |=> rsp_valid && rsp_error == ERR_RANGE)
      else $error("out-of-range order not rejected in the next cycle");

   a_ok_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error == ERR_NONE |-> rsp_result_order <= ORDER_TOP)
      else $error("result order above the top order");

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("block idle right after reset");

endmodule

bind buddy_page_free_and_split bpfs_checker u_bpfs_checker (.*);

// ----- sim/bpfs_checker.sv -----
// Checker for the buddy page allocator: tracks the page store, predicts each result and compares.
module bpfs_scoreboard (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_command,
   input  logic [bpfs_pkg::PFN_W-1:0]    req_block_pfn,
   input  logic [bpfs_pkg::ORD_W-1:0]    req_order,
   input  logic [bpfs_pkg::ORD_W-1:0]    req_target_order,
   input  logic                          rsp_valid,
   input  logic [bpfs_pkg::PFN_W-1:0]    rsp_result_pfn,
   input  logic [bpfs_pkg::ORD_W-1:0]    rsp_result_order,
   input  logic                          rsp_tail_hint,
   input  logic [1:0]                    rsp_error,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bpfs_pkg::ADDR_W-1:0]   paddr,
   input  logic [bpfs_pkg::DATA_W-1:0]   pwdata,
   input  logic [bpfs_pkg::DATA_W-1:0]   prdata,
   input  logic                          pready,
   output int                            fail_count,
   output int                            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import bpfs_pkg::*;

   localparam logic [ADDR_W-1:0] LIMIT_ADDR = {REG_LIMIT, 2'b00};

   typedef struct packed {
      logic [PFN_W-1:0] pfn;
      logic [ORD_W-1:0] ord;
      logic             tail;
      error_type        err;
   } outcome_type;

   bit               head_mark   [PAGE_TOTAL];
   logic [ORD_W-1:0] head_order  [PAGE_TOTAL];
   logic [CNT_W-1:0] order_tally [ORDER_COUNT];
   logic [LIMIT_W-1:0] page_limit;
   outcome_type      awaited_outcomes [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      page_limit    = LIMIT_RESET;
   end

   task automatic report(input string what);
      $display("%0t ns: %s", $time, what);
      fail_count++;
   endtask

   function automatic bit page_ok(input int p);
      return p < PAGE_TOTAL && p < int'(page_limit);
   endfunction

   function automatic bit free_buddy(input int p, input int o);
      return page_ok(p) && head_mark[p] && int'(head_order[p]) == o;
   endfunction

   function automatic outcome_type buddy_outcome(input command_type cmd,
                                                 input logic [PFN_W-1:0] pfn,
                                                 input logic [ORD_W-1:0] ord,
                                                 input logic [ORD_W-1:0] tgt);
      outcome_type res;
      int p, o, t, b, hb, h, half;
      res.pfn  = pfn;
      res.ord  = ord;
      res.tail = 1'b0;
      res.err  = ERR_NONE;
      p = int'(pfn);
      o = int'(ord);
      t = int'(tgt);
      if (o >= ORDER_COUNT || (cmd == CMD_SPLIT && t >= ORDER_COUNT)) begin
         res.err = ERR_RANGE;
      end else if ((p & ((1 << o) - 1)) != 0) begin
         res.err = ERR_ALIGN;
      end else if (cmd == CMD_FREE) begin
         while (o < ORDER_COUNT - 1 && free_buddy(p ^ (1 << o), o)) begin
            b = p ^ (1 << o);
            if (order_tally[o] != '0) order_tally[o]--;
            head_mark[b]  = 1'b0;
            head_order[b] = '0;
            p = p & b;
            o++;
         end
         head_mark[p]  = 1'b1;
         head_order[p] = ORD_W'(o);
         if (o + 2 < ORDER_COUNT) begin
            b = p ^ (1 << o);
            if (page_ok(b)) begin
               hb = (p & b) ^ (1 << (o + 1));
               if (free_buddy(hb, o + 1)) res.tail = 1'b1;
            end
         end
         if (order_tally[o] != COUNT_MAX) order_tally[o]++;
         res.pfn = PFN_W'(p);
         res.ord = ORD_W'(o);
      end else begin
         h = o;
         while (h > t) begin
            h--;
            half = p + (1 << h);
            if (half < PAGE_TOTAL) begin
               head_mark[half]  = 1'b1;
               head_order[half] = ORD_W'(h);
               if (order_tally[h] != COUNT_MAX) order_tally[h]++;
            end
         end
         res.ord = (t <= o) ? tgt : ord;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         foreach (head_mark[i]) begin
            head_mark[i]  = 1'b0;
            head_order[i] = '0;
         end
         foreach (order_tally[i]) order_tally[i] = '0;
         page_limit = LIMIT_RESET;
         awaited_outcomes.delete();
      end else begin
         if (psel && penable && pready && paddr == LIMIT_ADDR) begin
            if (pwrite) begin
               page_limit = pwdata[LIMIT_W-1:0];
            end else if (prdata !== DATA_W'(page_limit)) begin
               report($sformatf("limit read %0d, predicted %0d", prdata, page_limit));
            end
         end
         if (rsp_valid) begin
            if (awaited_outcomes.size() == 0) begin
               report("result transaction with no command outstanding");
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_result_pfn !== want.pfn)
                  report($sformatf("result_pfn %0d, predicted %0d", rsp_result_pfn, want.pfn));
               if (rsp_result_order !== want.ord)
                  report($sformatf("result_order %0d, predicted %0d",
                                   rsp_result_order, want.ord));
               if (rsp_tail_hint !== want.tail)
                  report($sformatf("tail_hint %0b, predicted %0b", rsp_tail_hint, want.tail));
               if (rsp_error !== want.err)
                  report($sformatf("error %0d, predicted %0d", rsp_error, want.err));
            end
         end
         if (start && !busy) begin
            awaited_outcomes.push_back(buddy_outcome(command_type'(req_command), req_block_pfn,
                                                     req_order, req_target_order));
         end
      end
      pending_count <= awaited_outcomes.size();
   end

endmodule

// ----- sim/testbench.sv -----
// Top of the buddy page allocator testbench: clock, reset, command and register stimulus, verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bpfs_pkg::*;

   localparam logic [ADDR_W-1:0] LIMIT_ADDR = {REG_LIMIT, 2'b00};
   localparam int PHASES = 5;
   localparam int ITEMS_PER_PHASE = 140;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_command;
   logic [PFN_W-1:0]   req_block_pfn;
   logic [ORD_W-1:0]   req_order;
   logic [ORD_W-1:0]   req_target_order;
   logic               rsp_valid;
   logic [PFN_W-1:0]   rsp_result_pfn;
   logic [ORD_W-1:0]   rsp_result_order;
   logic               rsp_tail_hint;
   logic [1:0]         rsp_error;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [ADDR_W-1:0]  paddr;
   logic [DATA_W-1:0]  pwdata;
   logic [DATA_W-1:0]  prdata;
   logic               pready;
   int                 fail_count;
   int                 pending_count;

   int                 sent_count;
   logic [PFN_W-1:0]   hot_base;

   buddy_page_free_and_split dut (.*);

   bpfs_scoreboard u_scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_command(input command_type cmd, input logic [PFN_W-1:0] pfn,
                               input logic [ORD_W-1:0] ord, input logic [ORD_W-1:0] tgt);
      bit calm;
      calm = sent_count >= 300 && sent_count < 420;
      if (!calm && $urandom_range(0, 99) < 22) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start            <= 1'b1;
      req_command      <= cmd;
      req_block_pfn    <= pfn;
      req_order        <= ord;
      req_target_order <= tgt;
      do @(posedge clock); while (busy);
      sent_count++;
   endtask

   task automatic register_access(input bit is_write, input logic [LIMIT_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= LIMIT_ADDR;
      pwdata  <= DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || busy);
   endtask

   function automatic logic [PFN_W-1:0] aligned_pfn(input int o);
      return PFN_W'($urandom_range(0, PAGE_TOTAL - 1)) & ~PFN_W'((1 << o) - 1);
   endfunction

   task automatic directed_commands();
      send_command(CMD_FREE, 0, 0, 0);
      send_command(CMD_FREE, 1, 0, 4'd15);
      send_command(CMD_FREE, PFN_LAST, 0, 0);
      send_command(CMD_FREE, 0, ORDER_TOP, 0);
      send_command(CMD_FREE, 1024, ORDER_TOP, 0);
      send_command(CMD_FREE, 3, 1, 0);
      send_command(CMD_FREE, 16, ORDER_LIM, 0);
      send_command(CMD_FREE, PFN_LAST, 4'd15, 4'd15);
      send_command(CMD_SPLIT, 64, 2, ORDER_LIM);
      send_command(CMD_SPLIT, 0, 4'd15, 0);
      send_command(CMD_SPLIT, 2048, ORDER_TOP, 0);
      send_command(CMD_FREE, 2048, 0, 0);
      send_command(CMD_SPLIT, 64, 2, 5);
      send_command(CMD_SPLIT, 128, 3, 3);
      send_command(CMD_SPLIT, 5, 3, 0);
      send_command(CMD_SPLIT, PFN_LAST, 0, 0);
      send_command(CMD_FREE, 258, 1, 0);
      send_command(CMD_FREE, 256, 0, 0);
      send_command(CMD_FREE, 256, 0, 0);
      send_command(CMD_SPLIT, 3072, ORDER_TOP, ORDER_TOP);
      send_command(CMD_FREE, 3584, 9, 0);
   endtask

   task automatic random_command();
      int kind, o, t;
      logic [PFN_W-1:0] pfn;
      kind = $urandom_range(0, 99);
      if (sent_count % 40 == 0) hot_base = PFN_W'($urandom_range(0, 63) * 64);
      if (kind < 30) begin
         o   = ($urandom_range(0, 9) == 0) ? $urandom_range(5, ORDER_COUNT - 1)
                                           : $urandom_range(1, 4);
         t   = $urandom_range(0, o - 1);
         pfn = aligned_pfn(o);
         send_command(CMD_SPLIT, pfn, ORD_W'(o), ORD_W'(t));
         send_command(CMD_FREE, pfn, ORD_W'(t), ORD_W'($urandom_range(0, 15)));
      end else if (kind < 60) begin
         o   = $urandom_range(0, 3);
         pfn = hot_base + (PFN_W'($urandom_range(0, 63)) & ~PFN_W'((1 << o) - 1));
         send_command(CMD_FREE, pfn, ORD_W'(o), ORD_W'($urandom_range(0, 15)));
      end else if (kind < 70) begin
         o   = $urandom_range(0, 6);
         pfn = hot_base + (PFN_W'($urandom_range(0, 63)) & ~PFN_W'((1 << o) - 1));
         send_command(CMD_SPLIT, pfn, ORD_W'(o), ORD_W'($urandom_range(0, o)));
      end else if (kind < 80) begin
         o = $urandom_range(0, ORDER_COUNT - 1);
         send_command(CMD_FREE, aligned_pfn(o), ORD_W'(o), ORD_W'($urandom_range(0, 15)));
      end else if (kind < 88) begin
         o = $urandom_range(0, ORDER_COUNT - 1);
         send_command(CMD_SPLIT, aligned_pfn(o), ORD_W'(o), ORD_W'($urandom_range(0, 15)));
      end else begin
         send_command(command_type'($urandom_range(0, 1)),
                      PFN_W'($urandom_range(0, PAGE_TOTAL - 1)),
                      ORD_W'($urandom_range(0, 15)), ORD_W'($urandom_range(0, 15)));
      end
   endtask

   initial begin
      int phase_limit [PHASES];
      int phase_end;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_command      <= CMD_FREE;
      req_block_pfn    <= '0;
      req_order        <= '0;
      req_target_order <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      sent_count        = 0;
      hot_base          = '0;
      phase_limit = '{PAGE_TOTAL, 1, $urandom_range(2, PAGE_TOTAL - 1), PAGE_TOTAL / 2,
                      PAGE_TOTAL};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         register_access(1'b1, LIMIT_W'(phase_limit[phase]));
         register_access(1'b0, '0);
         if (phase == 0) directed_commands();
         phase_end = (phase + 1) * ITEMS_PER_PHASE;
         while (sent_count < phase_end) random_command();
      end
      wait_drained();
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
